// ===== hdl/hamming_encode_correct_core_assert.svh =====
// assertion macros for the hamming encode/correct core checker
// no dependencies; included by the checker file
`ifndef HAMMING_ENCODE_CORRECT_CORE_ASSERT_SVH
`define HAMMING_ENCODE_CORRECT_CORE_ASSERT_SVH

// property checked every clock edge, ignored while reset is high
`define HEC_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// property checked every clock edge, reset included
`define HEC_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

// ===== hdl/hec_pkg.sv =====
// shared types, constants and functions for the hamming encode/correct core
// no dependencies
`default_nettype none

package hec_pkg;

   localparam int unsigned MAX_DATA_BITS = 57;
   localparam int unsigned WORD_W        = 63;
   localparam int unsigned LEN_W         = 6;

   localparam logic [LEN_W-1:0] RESET_DATA_LEN = LEN_W'(MAX_DATA_BITS);
   localparam logic [LEN_W-1:0] RESET_CODE_LEN = 6'd63;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [WORD_W-1:0] word;
   } hec_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic [LEN_W-1:0]  syndrome;
      logic              error_found;
      logic              syndrome_out_of_range;
   } hec_rsp_type;

   // data length and codeword length in effect
   typedef struct packed {
      logic [LEN_W-1:0] data_len;
      logic [LEN_W-1:0] code_len;
   } hec_len_type;

   // bring a written length into 1..MAX_DATA_BITS
   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] k;
      k = v;
      if (v == '0) begin
         k = LEN_W'(1);
      end else if (v > LEN_W'(MAX_DATA_BITS)) begin
         k = LEN_W'(MAX_DATA_BITS);
      end
      return k;
   endfunction

   // least r with 2^r >= k + r + 1 (condition is monotonic in r)
   function automatic logic [LEN_W-1:0] parity_count(input logic [LEN_W-1:0] k);
      logic [2:0] r;
      r = 3'd7;
      for (int i = 6; i >= 0; i--) begin
         if ((8'd1 << i) >= ({2'b00, k} + 8'(i) + 8'd1)) begin
            r = 3'(i);
         end
      end
      return {3'b000, r};
   endfunction

   // xor of the 1-based positions of all set bits
   function automatic logic [LEN_W-1:0] syndrome_of(input logic [WORD_W-1:0] w);
      logic [LEN_W-1:0] s;
      s = '0;
      for (int p = 1; p <= WORD_W; p++) begin
         if (w[p-1]) begin
            s = s ^ LEN_W'(p);
         end
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hec_csr.sv =====
// length register: holds the message length and the derived codeword length
// depends on hec_pkg
`default_nettype none

module hec_csr (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [hec_pkg::LEN_W-1:0] csr_data,
   output hec_pkg::hec_len_type          len
);

   hec_pkg::hec_len_type len_ff;
   hec_pkg::hec_len_type len_in;
   logic [hec_pkg::LEN_W-1:0] k;

   assign csr_ready = 1'b1;

   always_comb begin
      k = hec_pkg::clamp_len(csr_data);
      len_in = len_ff;
      if (csr_valid) begin
         len_in.data_len = k;
         len_in.code_len = k + hec_pkg::parity_count(k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff.data_len <= hec_pkg::RESET_DATA_LEN;
         len_ff.code_len <= hec_pkg::RESET_CODE_LEN;
      end else begin
         len_ff <= len_in;
      end
   end

   assign len = len_ff;

endmodule

`default_nettype wire

// ===== hdl/hec_codec.sv =====
// combinational hamming encoder and single-error corrector
// depends on hec_pkg
`default_nettype none

module hec_codec (
   input  hec_pkg::hec_req_type req,
   input  hec_pkg::hec_len_type len,
   output hec_pkg::hec_rsp_type rsp
);

   logic [hec_pkg::WORD_W-1:0] kmask;
   logic [hec_pkg::WORD_W-1:0] nmask;
   logic [hec_pkg::WORD_W-1:0] placed;
   logic [hec_pkg::WORD_W-1:0] enc_word;
   logic [hec_pkg::WORD_W-1:0] dec_word;
   logic [hec_pkg::WORD_W-1:0] flip;
   logic [hec_pkg::LEN_W-1:0]  enc_syn;
   logic [hec_pkg::LEN_W-1:0]  dec_syn;
   logic [hec_pkg::LEN_W-1:0]  d;
   logic                       oor;

   always_comb begin
      for (int i = 0; i < hec_pkg::WORD_W; i++) begin
         kmask[i] = (hec_pkg::LEN_W'(i) < len.data_len);
         nmask[i] = (hec_pkg::LEN_W'(i) < len.code_len);
      end

      // spread data bits over the non-power-of-two positions
      d = '0;
      placed = '0;
      for (int p = 1; p <= hec_pkg::WORD_W; p++) begin
         if ((p & (p - 1)) != 0) begin
            placed[p-1] = req.word[d] & kmask[d];
            d = d + hec_pkg::LEN_W'(1);
         end
      end

      // parity bit 2^i takes bit i of the data position xor
      enc_syn = hec_pkg::syndrome_of(placed);
      enc_word = placed;
      for (int i = 0; i < hec_pkg::LEN_W; i++) begin
         enc_word[(1 << i) - 1] = enc_syn[i];
      end
      enc_word = enc_word & nmask;

      // decode: syndrome names the bad position
      dec_word = req.word & nmask;
      dec_syn  = hec_pkg::syndrome_of(dec_word);
      oor      = (dec_syn > len.code_len);
      for (int i = 0; i < hec_pkg::WORD_W; i++) begin
         flip[i] = (dec_syn == hec_pkg::LEN_W'(i + 1)) && !oor;
      end

      if (req.mode == hec_pkg::MODE_DECODE) begin
         rsp.result_word           = dec_word ^ flip;
         rsp.syndrome              = dec_syn;
         rsp.error_found           = (dec_syn != '0);
         rsp.syndrome_out_of_range = oor;
      end else begin
         rsp.result_word           = enc_word;
         rsp.syndrome              = '0;
         rsp.error_found           = 1'b0;
         rsp.syndrome_out_of_range = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hamming_encode_correct_core.sv =====
// top level of the hamming encode/correct core
// depends on hec_pkg, hec_csr and hec_codec
//
// usage
//  - req channel: one transaction carries mode and word; mode 0 encodes the
//    low message_length bits of word, mode 1 checks and corrects a codeword
//  - rsp channel: one transaction per request, in order, with the codeword,
//    syndrome and the two error flags
//  - csr channel: writes message_length (1..57, out-of-range values clamp);
//    write only while no request is in flight; csr_ready is always high
//  - path: an accepted request passes the input register, the codec logic and
//    the result register, in that order, before rsp_valid rises; while the
//    result register is full and stalled, the request waits in the input one
//  - throughput: one transaction per cycle while rsp_ready stays high; the
//    codec is a single pass of xor trees between the input and result registers
//  - reset: synchronous; empties both stages and sets message_length to 57
//  - stall: a held rsp keeps its payload; the input stage still takes a new
//    transaction while the result register is full, then req_ready drops
//    until rsp_ready frees the result register
`default_nettype none

module hamming_encode_correct_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  hec_pkg::hec_req_type           req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output hec_pkg::hec_rsp_type           rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [hec_pkg::LEN_W-1:0] csr_data
);

   hec_pkg::hec_len_type len;

   // input stage
   logic                 in_valid_ff;
   logic                 in_valid_in;
   hec_pkg::hec_req_type in_data_ff;

   // result stage
   logic                 out_valid_ff;
   logic                 out_valid_in;
   hec_pkg::hec_rsp_type out_data_ff;
   hec_pkg::hec_rsp_type codec_rsp;

   logic out_load;
   logic in_load;

   hec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .len       (len)
   );

   hec_codec u_codec (
      .req (in_data_ff),
      .len (len),
      .rsp (codec_rsp)
   );

   // result register takes the codec output when empty or being drained
   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   // input register refills when empty or when its item moves on
   assign req_ready = !in_valid_ff || out_load;
   assign in_load   = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         in_valid_in = 1'b0;
      end
      if (in_load) begin
         in_valid_in = 1'b1;
      end
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= codec_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

// ===== hdl/hec_checker.sv =====
// port-level checker for the hamming encode/correct core, bound to the top
// depends on hec_pkg and hamming_encode_correct_core_assert.svh
`default_nettype none
`include "hamming_encode_correct_core_assert.svh"

module hec_checker (
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           rsp_valid,
   input wire logic           rsp_ready,
   input hec_pkg::hec_rsp_type rsp_data
);

   // error flag mirrors a nonzero syndrome
   `HEC_ASSERT_RST(a_err_flag, clock, reset, rsp_valid |-> (rsp_data.error_found == (rsp_data.syndrome != '0)))
   // out-of-range only on a detected error
   `HEC_ASSERT_RST(a_oor_err, clock, reset, (rsp_valid && rsp_data.syndrome_out_of_range) |-> rsp_data.error_found)
   // stalled result holds
   `HEC_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
   // reset empties the result stage
   `HEC_ASSERT(a_rst_empty, clock, reset |=> !rsp_valid)

endmodule

bind hamming_encode_correct_core hec_checker u_hec_checker (.*);

`default_nettype wire

// ===== tb/hamming_encode_correct_core_tb.sv =====
// self-checking testbench for hamming_encode_correct_core: directed vectors, then random traffic
// checks each response against a literal or a behavioral hamming prediction; depends on hec_pkg
`timescale 1ns / 1ps

module hamming_encode_correct_core_tb;

   localparam int RAND_ITEMS  = 1300;  // random request transactions
   localparam int TAIL_ITEMS  = 150;   // final stretch run with no idling
   localparam int WDOG_LIMIT  = 2000;  // cycles without any transaction
   localparam int DRAIN_WAIT  = 10;    // quiet cycles after the last response

   // one directed vector: length to program, request, optional literal response
   typedef struct packed {
      logic [hec_pkg::LEN_W-1:0] msg_len;
      hec_pkg::hec_req_type      req;
      logic                      typed;
      hec_pkg::hec_rsp_type      rsp;
   } dir_row_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   hec_pkg::hec_req_type      req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   hec_pkg::hec_rsp_type      rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [hec_pkg::LEN_W-1:0] csr_data  = '0;

   // testbench copy of message_length, updated on each csr transaction
   logic [hec_pkg::LEN_W-1:0] msg_len = hec_pkg::RESET_DATA_LEN;
   // responses still owed by the block, oldest first
   hec_pkg::hec_rsp_type      pending_hamming_rsp[$];
   dir_row_type               directed_rows[$];
   int                        fail_count  = 0;
   int                        idle_cycles = 0;
   // 0 disables idling, otherwise a burst starts with odds 1 in stall_odds
   int unsigned               stall_odds  = 4;

   hamming_encode_correct_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // data length in effect: zero reads as one, above the maximum clamps
   function automatic int data_bits(input logic [hec_pkg::LEN_W-1:0] v);
      int k;
      k = int'(v);
      if (k < 1) begin
         k = 1;
      end else if (k > int'(hec_pkg::MAX_DATA_BITS)) begin
         k = int'(hec_pkg::MAX_DATA_BITS);
      end
      return k;
   endfunction

   // smallest r with 2^r >= k + r + 1
   function automatic int check_bits(input int k);
      int r;
      r = 0;
      while ((1 << r) < k + r + 1) begin
         r++;
      end
      return r;
   endfunction

   function automatic logic [hec_pkg::WORD_W-1:0] code_mask(input int n);
      logic [hec_pkg::WORD_W-1:0] m;
      m = (n >= int'(hec_pkg::WORD_W)) ? '1 :
          ((hec_pkg::WORD_W'(1) << n) - hec_pkg::WORD_W'(1));
      return m;
   endfunction

   function automatic logic [hec_pkg::WORD_W-1:0] rand_word();
      return hec_pkg::WORD_W'({$urandom(), $urandom()});
   endfunction

   // behavioral model of one request under a given message_length
   function automatic hec_pkg::hec_rsp_type predict_hamming(
      input hec_pkg::hec_req_type      rq,
      input logic [hec_pkg::LEN_W-1:0] len_reg);
      hec_pkg::hec_rsp_type       rs;
      int                         k;
      int                         n;
      int                         d;
      int                         acc;
      int                         syn;
      logic [hec_pkg::WORD_W-1:0] w;
      k  = data_bits(len_reg);
      n  = k + check_bits(k);
      rs = '0;
      if (rq.mode == hec_pkg::MODE_ENCODE) begin
         // data bits fill the non power-of-two positions in order
         d   = 0;
         acc = 0;
         for (int p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
               if (rq.word[d]) begin
                  rs.result_word[p-1] = 1'b1;
                  acc = acc ^ p;
               end
               d++;
            end
         end
         // parity bit 2^i is bit i of the xor of the set data positions
         for (int p = 1; p <= n; p = p << 1) begin
            if ((acc & p) != 0) begin
               rs.result_word[p-1] = 1'b1;
            end
         end
      end else begin
         w   = rq.word & code_mask(n);
         syn = 0;
         for (int p = 1; p <= n; p++) begin
            if (w[p-1]) begin
               syn = syn ^ p;
            end
         end
         rs.result_word = w;
         rs.syndrome    = hec_pkg::LEN_W'(syn);
         rs.error_found = (syn != 0);
         if (syn > n) begin
            // syndrome names a position past the codeword: flag it, no repair
            rs.syndrome_out_of_range = 1'b1;
         end else if (syn != 0) begin
            rs.result_word[syn-1] = ~rs.result_word[syn-1];
         end
      end
      return rs;
   endfunction

   task automatic add_vector(input logic [hec_pkg::LEN_W-1:0] len, input logic mode,
                             input logic [hec_pkg::WORD_W-1:0] word, input logic typed,
                             input logic [hec_pkg::WORD_W-1:0] rword,
                             input logic [hec_pkg::LEN_W-1:0] syn,
                             input logic ef, input logic oor);
      dir_row_type row;
      row.msg_len                   = len;
      row.req.mode                  = mode;
      row.req.word                  = word;
      row.typed                     = typed;
      row.rsp.result_word           = rword;
      row.rsp.syndrome              = syn;
      row.rsp.error_found           = ef;
      row.rsp.syndrome_out_of_range = oor;
      directed_rows.push_back(row);
   endtask

   // one request transaction; entered and left at a falling edge
   task automatic send_req(input hec_pkg::hec_req_type item, input logic typed,
                           input hec_pkg::hec_rsp_type typed_rsp);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      // the expectation is fixed by the length in force at acceptance
      if (typed) begin
         pending_hamming_rsp.push_back(typed_rsp);
      end else begin
         pending_hamming_rsp.push_back(predict_hamming(item, msg_len));
      end
      @(negedge clock);
   endtask

   // program message_length once every owed response has come back
   task automatic write_msg_len(input logic [hec_pkg::LEN_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_hamming_rsp.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      msg_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response side backpressure: bursts of rsp_ready low
   initial begin
      forever begin
         @(negedge clock);
         if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // response checker: compare each transaction against the oldest expectation
   always @(posedge clock) begin : rsp_check
      hec_pkg::hec_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_hamming_rsp.size() == 0) begin
            $error("unexpected response transaction: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_hamming_rsp.pop_front();
            if (rsp_data.result_word !== want.result_word) begin
               $error("result_word: expected %h, got %h",
                      want.result_word, rsp_data.result_word);
               fail_count++;
            end
            if (rsp_data.syndrome !== want.syndrome) begin
               $error("syndrome: expected %0d, got %0d", want.syndrome, rsp_data.syndrome);
               fail_count++;
            end
            if (rsp_data.error_found !== want.error_found) begin
               $error("error_found: expected %b, got %b",
                      want.error_found, rsp_data.error_found);
               fail_count++;
            end
            if (rsp_data.syndrome_out_of_range !== want.syndrome_out_of_range) begin
               $error("syndrome_out_of_range: expected %b, got %b",
                      want.syndrome_out_of_range, rsp_data.syndrome_out_of_range);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("hamming_encode_correct_core_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [hec_pkg::LEN_W-1:0]  corner_lens[8];
      logic [hec_pkg::LEN_W-1:0]  len;
      logic [hec_pkg::WORD_W-1:0] nmask;
      logic [hec_pkg::WORD_W-1:0] cw;
      hec_pkg::hec_req_type       item;
      hec_pkg::hec_req_type       enc_req;
      int                         n;
      int                         sent;
      int                         count;
      int                         flips;
      int                         pos;

      corner_lens = '{6'd0, 6'd1, 6'd4, 6'd11, 6'd26, 6'd57, 6'd58, 6'd63};

      // directed vectors; literal responses only where obvious
      // length 57 at reset: 63-bit codeword, all-ones data gives all-ones code
      add_vector(6'd57, hec_pkg::MODE_ENCODE, 63'h0, 1'b1, 63'h0, 6'd0, 1'b0, 1'b0);
      add_vector(6'd57, hec_pkg::MODE_ENCODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                 63'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, 1'b0);
      add_vector(6'd57, hec_pkg::MODE_DECODE, 63'h0, 1'b1, 63'h0, 6'd0, 1'b0, 1'b0);
      add_vector(6'd57, hec_pkg::MODE_DECODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                 63'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, 1'b0);
      // single error at the first and at the last position
      add_vector(6'd57, hec_pkg::MODE_DECODE, 63'h1, 1'b1, 63'h0, 6'd1, 1'b1, 1'b0);
      add_vector(6'd57, hec_pkg::MODE_DECODE, 63'h4000_0000_0000_0000, 1'b1,
                 63'h0, 6'd63, 1'b1, 1'b0);
      add_vector(6'd57, hec_pkg::MODE_ENCODE, 63'h1, 1'b1, 63'h7, 6'd0, 1'b0, 1'b0);
      add_vector(6'd57, hec_pkg::MODE_ENCODE, 63'h0155_AA33_CC0F_F0E1, 1'b0,
                 '0, '0, 1'b0, 1'b0);
      add_vector(6'd57, hec_pkg::MODE_DECODE, 63'h5555_5555_5555_5555, 1'b0,
                 '0, '0, 1'b0, 1'b0);
      // shortest code: data bits above the first are ignored
      add_vector(6'd1, hec_pkg::MODE_ENCODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                 63'h7, 6'd0, 1'b0, 1'b0);
      add_vector(6'd1, hec_pkg::MODE_ENCODE, 63'h0, 1'b1, 63'h0, 6'd0, 1'b0, 1'b0);
      // codeword bits past position 3 ignored and read back as zero
      add_vector(6'd1, hec_pkg::MODE_DECODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                 63'h7, 6'd0, 1'b0, 1'b0);
      add_vector(6'd1, hec_pkg::MODE_DECODE, 63'h4, 1'b1, 63'h0, 6'd3, 1'b1, 1'b0);
      // a zero length acts as one
      add_vector(6'd0, hec_pkg::MODE_ENCODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                 63'h7, 6'd0, 1'b0, 1'b0);
      // nine-bit code: syndrome 10 points past the codeword, nothing flipped
      add_vector(6'd5, hec_pkg::MODE_DECODE, 63'h82, 1'b1, 63'h82, 6'd10, 1'b1, 1'b1);
      add_vector(6'd5, hec_pkg::MODE_DECODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0,
                 '0, '0, 1'b0, 1'b0);
      add_vector(6'd5, hec_pkg::MODE_ENCODE, 63'h1F, 1'b0, '0, '0, 1'b0, 1'b0);
      add_vector(6'd4, hec_pkg::MODE_DECODE, 63'h7F, 1'b0, '0, '0, 1'b0, 1'b0);
      // lengths above the maximum clamp to 57
      add_vector(6'd63, hec_pkg::MODE_ENCODE, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1,
                 63'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, 1'b0);
      add_vector(6'd63, hec_pkg::MODE_DECODE, 63'h2000_0000_0000_0000, 1'b1,
                 63'h0, 6'd62, 1'b1, 1'b0);
      add_vector(6'd26, hec_pkg::MODE_ENCODE, 63'h2A5_C3F1, 1'b0, '0, '0, 1'b0, 1'b0);
      add_vector(6'd58, hec_pkg::MODE_DECODE, 63'h3, 1'b1, 63'h7, 6'd3, 1'b1, 1'b0);

      // synchronous reset, released at a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].msg_len != msg_len) begin
            write_msg_len(directed_rows[i].msg_len);
         end
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end

      // random phases, each but the tail under its own message_length
      sent = 0;
      while (sent < RAND_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            len = corner_lens[$urandom_range(0, 7)];
         end else begin
            len = hec_pkg::LEN_W'($urandom_range(0, 63));
         end
         // the tail keeps the length in force so the request stream has no gap
         if (sent < RAND_ITEMS - TAIL_ITEMS) begin
            write_msg_len(len);
         end
         n     = data_bits(msg_len) + check_bits(data_bits(msg_len));
         nmask = code_mask(n);
         // some phases run with no idling at all
         stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         count = $urandom_range(40, 140);
         for (int j = 0; j < count && sent < RAND_ITEMS; j++) begin
            if (sent >= RAND_ITEMS - TAIL_ITEMS) begin
               stall_odds = 0;
            end
            item.mode = $urandom_range(0, 1) ? hec_pkg::MODE_DECODE : hec_pkg::MODE_ENCODE;
            if (item.mode == hec_pkg::MODE_ENCODE || $urandom_range(0, 3) == 0) begin
               // raw data, or a noise codeword
               item.word = rand_word();
            end else begin
               // valid codeword with zero, one or two bits flipped
               enc_req.mode = hec_pkg::MODE_ENCODE;
               enc_req.word = rand_word();
               cw    = predict_hamming(enc_req, msg_len).result_word;
               flips = $urandom_range(0, 5);
               flips = (flips < 2) ? 0 : ((flips < 5) ? 1 : 2);
               for (int f = 0; f < flips; f++) begin
                  pos     = $urandom_range(0, n - 1);
                  cw[pos] = ~cw[pos];
               end
               // junk above the codeword must be ignored
               if ($urandom_range(0, 3) == 0) begin
                  cw = cw | (rand_word() & ~nmask);
               end
               item.word = cw;
            end
            send_req(item, 1'b0, '0);
            sent++;
         end
      end

      // drain: every owed response back, then a quiet wait before the verdict
      req_valid <= 1'b0;
      while (pending_hamming_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("hamming_encode_correct_core_tb OK");
      end else begin
         $display("hamming_encode_correct_core_tb NOT OK");
      end
      $finish;
   end

endmodule
